[src/wsd_pkg.sv]
// Package with the word types, phase codes and header constants of the WebSocket deframer.
`default_nettype none
package wsd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } wsd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       message_end;
    logic       discard;
  } wsd_out_t;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DONE    = 6'b100000
  } wsd_phase_e;

  localparam logic [3:0] OPCODE_TEXT  = 4'h1;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [2:0] EXT16_LAST   = 3'd1;
  localparam logic [2:0] EXT64_LAST   = 3'd7;
  localparam logic [1:0] KEY_LAST     = 2'd3;

endpackage
`default_nettype wire

[src/wsd_stream_if.sv]
// Valid/ready stream interface that carries one word per handshake.
`default_nettype none
interface wsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/websocket_frame_deframer_top.sv]
// Top level of the WebSocket frame deframer: header parser, unmasking and output register.
// The block parses one WebSocket frame at the start of each receive buffer and emits
// the unmasked payload bytes of a text frame, one input word per clock cycle unless the
// output stalls. The 64-bit length is held as a down-counter, so the compare and decrement
// on it set the cycle time. A result word is written to an output register; a new input
// word is taken whenever that register is empty or is being read in the same cycle. Words
// that produce no result (header bytes, non-text payload, bytes after the frame) are
// consumed without output. A buffer that ends before a text frame is complete yields a
// word with discard set, and all parser state returns to the first header byte.
`default_nettype none
module websocket_frame_deframer_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wsd_stream_if.sink   in_i,
  wsd_stream_if.source out_o
);
  import wsd_pkg::*;

  wsd_phase_e  phase_q, phase_d;
  logic        text_q, text_d;
  logic        masked_q, masked_d;
  logic [2:0]  len_cnt_q, len_cnt_d;
  logic [1:0]  key_cnt_q, key_cnt_d;
  logic [1:0]  idx_q, idx_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic        ovalid_q;
  wsd_out_t    out_q, res;
  logic        emit, accept, after_len;
  logic [7:0]  b, kb;

  assign b         = in_i.data.rx_byte;
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    phase_d   = phase_q;
    text_d    = text_q;
    masked_d  = masked_q;
    len_cnt_d = len_cnt_q;
    key_cnt_d = key_cnt_q;
    idx_d     = idx_q;
    len_d     = len_q;
    key_d     = key_q;
    emit      = 1'b0;
    after_len = 1'b0;
    res       = '0;
    kb        = 8'h00;
    case (phase_q)
      PH_HDR0: begin
        text_d  = (b[3:0] == OPCODE_TEXT);
        phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        masked_d = b[7];
        if (b[6:0] == LEN_CODE_16) begin
          len_d     = '0;
          len_cnt_d = EXT16_LAST;
          phase_d   = PH_EXTLEN;
        end else if (b[6:0] == LEN_CODE_64) begin
          len_d     = '0;
          len_cnt_d = EXT64_LAST;
          phase_d   = PH_EXTLEN;
        end else begin
          len_d     = {57'd0, b[6:0]};
          after_len = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_d = {len_q[55:0], b};
        if (len_cnt_q == 3'd0) begin
          after_len = 1'b1;
        end else begin
          len_cnt_d = len_cnt_q - 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], b};
        if (key_cnt_q == 2'd0) begin
          idx_d   = 2'd0;
          phase_d = (len_q == 64'd0) ? PH_DONE : PH_PAYLOAD;
        end else begin
          key_cnt_d = key_cnt_q - 2'd1;
        end
      end
      PH_PAYLOAD: begin
        case (idx_q)
          2'd0:    kb = key_q[31:24];
          2'd1:    kb = key_q[23:16];
          2'd2:    kb = key_q[15:8];
          default: kb = key_q[7:0];
        endcase
        idx_d = idx_q + 2'd1;
        len_d = len_q - 64'd1;
        if (len_q == 64'd1) begin
          phase_d = PH_DONE;
        end
        if (text_q) begin
          emit            = 1'b1;
          res.byte_valid  = 1'b1;
          res.out_byte    = masked_q ? (b ^ kb) : b;
          res.message_end = (len_q == 64'd1);
        end
      end
      default: begin
      end
    endcase

    if (after_len) begin
      if (masked_d) begin
        key_cnt_d = KEY_LAST;
        key_d     = '0;
        phase_d   = PH_KEY;
      end else begin
        idx_d   = 2'd0;
        phase_d = (len_d == 64'd0) ? PH_DONE : PH_PAYLOAD;
      end
    end

    if (in_i.data.buffer_end) begin
      if (text_d && (phase_d != PH_DONE)) begin
        res.discard     = 1'b1;
        res.message_end = 1'b0;
        emit            = 1'b1;
      end
      phase_d   = PH_HDR0;
      text_d    = 1'b0;
      masked_d  = 1'b0;
      len_cnt_d = 3'd0;
      key_cnt_d = 2'd0;
      idx_d     = 2'd0;
      len_d     = '0;
      key_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      text_q    <= 1'b0;
      masked_q  <= 1'b0;
      len_cnt_q <= 3'd0;
      key_cnt_q <= 2'd0;
      idx_q     <= 2'd0;
      ovalid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        text_q    <= text_d;
        masked_q  <= masked_d;
        len_cnt_q <= len_cnt_d;
        key_cnt_q <= key_cnt_d;
        idx_q     <= idx_d;
      end
      if (accept && emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q <= len_d;
      key_q <= key_d;
    end
    if (accept && emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = out_q;

  a_out_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (out_q.byte_valid || out_q.discard))
    else $error("result word carries neither a byte nor discard");

  a_end_not_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_q.message_end |-> out_q.byte_valid && !out_q.discard)
    else $error("message end without a clean payload byte");

  a_buffer_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.data.buffer_end |=> phase_q == PH_HDR0)
    else $error("parser did not return to the header after buffer end");

  a_byte_needs_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit && res.byte_valid |-> text_q && phase_q == PH_PAYLOAD)
    else $error("payload byte emitted outside a text payload");

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for the WebSocket frame deframer: directed and random receive buffers and byte-level checking.
`timescale 1ns / 1ps
module tb;
  import wsd_pkg::*;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_BYTES = 1850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  wsd_in_t  in_data = '0;
  logic     out_ready = 1'b0;

  wsd_stream_if #(.T(wsd_in_t))  in_if ();
  wsd_stream_if #(.T(wsd_out_t)) out_if ();

  assign in_if.valid = in_valid;
  assign in_if.data  = in_data;
  assign out_if.ready = out_ready;

  websocket_frame_deframer_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  wsd_in_t  rx_queue[$];
  wsd_out_t expected_out[$];
  int       err_count = 0;
  int       rx_total = 0;
  int       idle_cycles = 0;

  wsd_phase_e  pr_phase;
  logic        pr_text;
  logic        pr_masked;
  int          pr_len_left;
  int          pr_key_left;
  logic [63:0] pr_len;
  logic [63:0] pr_idx;
  logic [31:0] pr_key;

  function automatic void clear_parser();
    pr_phase    = PH_HDR0;
    pr_text     = 1'b0;
    pr_masked   = 1'b0;
    pr_len_left = 0;
    pr_key_left = 0;
    pr_len      = '0;
    pr_idx      = '0;
    pr_key      = '0;
  endfunction

  function automatic void open_payload();
    pr_idx   = '0;
    pr_phase = (pr_len == 64'd0) ? PH_DONE : PH_PAYLOAD;
  endfunction

  function automatic void finish_length();
    if (pr_masked) begin
      pr_key_left = 4;
      pr_key      = '0;
      pr_phase    = PH_KEY;
    end else begin
      open_payload();
    end
  endfunction

  function automatic void predict_rx_byte(input wsd_in_t w);
    logic [7:0] b;
    logic [7:0] v;
    logic       emit;
    logic       fin;
    logic       mend;
    logic       disc;
    wsd_out_t   r;
    b    = w.rx_byte;
    v    = b;
    emit = 1'b0;
    mend = 1'b0;
    disc = 1'b0;
    case (pr_phase)
      PH_HDR0: begin
        pr_text  = (b[3:0] == OPCODE_TEXT);
        pr_phase = PH_HDR1;
      end
      PH_HDR1: begin
        pr_masked = b[7];
        pr_len    = '0;
        if (b[6:0] == LEN_CODE_16) begin
          pr_len_left = 2;
          pr_phase    = PH_EXTLEN;
        end else if (b[6:0] == LEN_CODE_64) begin
          pr_len_left = 8;
          pr_phase    = PH_EXTLEN;
        end else begin
          pr_len = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PH_EXTLEN: begin
        pr_len      = {pr_len[55:0], b};
        pr_len_left = pr_len_left - 1;
        if (pr_len_left == 0) finish_length();
      end
      PH_KEY: begin
        pr_key      = {pr_key[23:0], b};
        pr_key_left = pr_key_left - 1;
        if (pr_key_left == 0) open_payload();
      end
      PH_PAYLOAD: begin
        if (pr_masked) v = b ^ pr_key[8 * (3 - pr_idx[1:0]) +: 8];
        pr_idx = pr_idx + 64'd1;
        fin    = (pr_idx == pr_len);
        if (fin) pr_phase = PH_DONE;
        if (pr_text) begin
          emit = 1'b1;
          mend = fin;
        end
      end
      default: ;
    endcase
    if (w.buffer_end) begin
      if (pr_text && pr_phase != PH_DONE) begin
        disc = 1'b1;
        mend = 1'b0;
      end
      clear_parser();
    end
    if (emit || disc) begin
      r.out_byte    = emit ? v : 8'd0;
      r.byte_valid  = emit;
      r.message_end = mend;
      r.discard     = disc;
      expected_out.insert(expected_out.size(), r);
    end
  endfunction

  task automatic queue_buffer(input logic [7:0] hdr0, input logic masked, input len_form_e form,
                              input logic [63:0] plen, input logic [31:0] key, input int npay,
                              input int ntrail, input int cut);
    logic [7:0] frame[$];
    wsd_in_t    w;
    int         k;
    frame.insert(frame.size(), hdr0);
    case (form)
      LEN_SHORT: frame.insert(frame.size(), {masked, plen[6:0]});
      LEN_EXT16: begin
        frame.insert(frame.size(), {masked, LEN_CODE_16});
        frame.insert(frame.size(), plen[15:8]);
        frame.insert(frame.size(), plen[7:0]);
      end
      default: begin
        frame.insert(frame.size(), {masked, LEN_CODE_64});
        for (k = 7; k >= 0; k--) frame.insert(frame.size(), plen[8 * k +: 8]);
      end
    endcase
    if (masked) for (k = 3; k >= 0; k--) frame.insert(frame.size(), key[8 * k +: 8]);
    for (k = 0; k < npay + ntrail; k++) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    if (cut > 0) while (frame.size() > cut) void'(frame.pop_back());
    for (k = 0; k < frame.size(); k++) begin
      w.rx_byte    = frame[k];
      w.buffer_end = (k == frame.size() - 1);
      rx_queue.insert(rx_queue.size(), w);
    end
    rx_total += frame.size();
  endtask

  task automatic drain_rx();
    do @(negedge clk); while (rx_queue.size() != 0 || in_valid || expected_out.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  int burst_left;
  int gap_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
      clear_parser();
    end else begin
      if (in_valid && in_if.ready) predict_rx_byte(in_data);
      if (!in_valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (rx_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= rx_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int stall_mode;
  int mode_left;

  always @(posedge clk or negedge rst_n) begin : monitor
    wsd_out_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (out_if.valid && out_ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected word byte=%h valid=%b end=%b discard=%b", $time,
                   out_if.data.out_byte, out_if.data.byte_valid, out_if.data.message_end,
                   out_if.data.discard);
          err_count++;
        end else begin
          want = expected_out.pop_front();
          if (out_if.data.out_byte !== want.out_byte ||
              out_if.data.byte_valid !== want.byte_valid ||
              out_if.data.message_end !== want.message_end ||
              out_if.data.discard !== want.discard) begin
            $write("%0t: mismatch expected byte=%h valid=%b end=%b discard=%b,",
                   $time, want.out_byte, want.byte_valid, want.message_end, want.discard);
            $display(" actual byte=%h valid=%b end=%b discard=%b",
                     out_if.data.out_byte, out_if.data.byte_valid, out_if.data.message_end,
                     out_if.data.discard);
            err_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(32, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (mode_left[1:0] == 2'd0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_if.ready) || (out_if.valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0]  hdr0;
    logic        masked;
    len_form_e   form;
    logic [63:0] plen;
    int          pick;
    int          npay;
    int          ntrail;
    int          cut;
    bit          paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A text header cut after its first byte, then an empty text frame.
    queue_buffer(8'h81, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0, 0, 1);
    queue_buffer(8'h81, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0, 0, 0);
    // A control frame with trailing bytes stays silent.
    queue_buffer(8'hFF, 1'b0, LEN_SHORT, 64'd1, 32'd0, 1, 1, 0);
    // A masked text frame followed by bytes that must be ignored.
    queue_buffer(8'hF1, 1'b1, LEN_SHORT, 64'd3, 32'hFFFF_FFFF, 3, 2, 0);
    // A maximal 64-bit length never completes.
    queue_buffer(8'h81, 1'b0, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 2, 0, 0);
    // A masked text frame whose buffer ends inside the mask key.
    queue_buffer(8'h81, 1'b1, LEN_EXT16, 64'd2, 32'h0000_0000, 2, 0, 6);
    drain_rx();

    rx_total = 0;
    while (rx_total < RANDOM_BYTES) begin
      hdr0 = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 7) hdr0[3:0] = OPCODE_TEXT;
      masked = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      form = (pick < 7) ? LEN_SHORT : (pick < 9) ? LEN_EXT16 : LEN_EXT64;
      case (form)
        LEN_SHORT: plen = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 125))
                                                     : 64'($urandom_range(0, 12));
        LEN_EXT16: plen = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 65535))
                                                     : 64'($urandom_range(0, 40));
        default:   plen = ($urandom_range(0, 5) == 0) ? {$urandom, $urandom}
                                                     : 64'($urandom_range(0, 40));
      endcase
      npay   = (plen > 64'd130) ? $urandom_range(0, 40) : int'(plen);
      ntrail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      cut    = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0;
      queue_buffer(hdr0, masked, form, plen, $urandom, npay, ntrail, cut);
      if (!paused && rx_total >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        drain_rx();
      end
    end
    drain_rx();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
